// File: rtl/rtat_pkg.sv
package rtat_pkg;

  localparam int PROG_W = 16;
  localparam int TIME_W = 32;
  localparam int RECT_W = 64;
  localparam int COMP_W = 16;
  localparam int NLANES = 4;
  localparam int CNT_W = $clog2(PROG_W);

  localparam logic [TIME_W-1:0] RESET_DURATION = 32'd250;
  localparam logic [TIME_W-1:0] DURATION_INFINITE = '1;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SCHEDULE = 2'd1;
  localparam logic [1:0] ACT_UNSCHEDULE = 2'd2;

  localparam logic [1:0] REG_DELAY = 2'd0;
  localparam logic [1:0] REG_DURATION = 2'd1;
  localparam logic [1:0] REG_FROM = 2'd2;
  localparam logic [1:0] REG_TO = 2'd3;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_STARTED = 2'd1,
    EV_UPDATE = 2'd2,
    EV_STOPPED = 2'd3
  } event_t;

endpackage

// File: rtl/rect_tween_animation_timer.sv
// Linear tween timer for one rectangle animation channel.
// Requests arrive on in_valid/in_ready with an action (tick, schedule,
// unschedule) and a millisecond timestamp; each request yields exactly one
// result on out_valid/out_ready carrying an event code, a finished flag, the
// progress and the interpolated rectangle.
// Delay, duration and the two rectangles are written through the cfg channel,
// which is always ready; writes are meant to happen while the block is idle.
// A request that does not produce a value update goes straight to the output
// state, where its result is loaded once the result register is free. A value
// update runs through a product step, a 16-step bit-serial restoring division
// of PROGRESS_MAX times elapsed by the duration, a second product step, four
// parallel 16-step bit-serial divisions by PROGRESS_MAX that scale each
// rectangle component, and the load. With an infinite duration the first
// division is skipped. One request is processed at a time. The result register
// is separate from the working registers: the next request is taken while a
// result waits, and a stalled receiver only holds back the write of the next
// result.
// Synchronous reset makes the channel unscheduled, clears the start time,
// sets the duration to 250 ms and clears delay, rectangles and flags.
module rect_tween_animation_timer #(
  parameter int PROGRESS_MAX = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_res,
  output logic               finished,
  output logic [15:0]        progress,
  output logic signed [15:0] rect_x,
  output logic signed [15:0] rect_y,
  output logic signed [15:0] rect_w,
  output logic signed [15:0] rect_h,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import rtat_pkg::*;

  localparam logic [PROG_W-1:0] PMAX = PROG_W'(PROGRESS_MAX);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROG_W - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_DELAY, PH_RUN} phase_t;
  typedef enum logic [2:0] {ST_IDLE, ST_MUL1, ST_DIV, ST_MUL2, ST_LERP, ST_OUT} state_t;

  state_t state;
  phase_t phase;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] delay_len;
  logic [TIME_W-1:0] run_len;
  logic [RECT_W-1:0] from_rect;
  logic [RECT_W-1:0] to_rect;
  logic [CNT_W-1:0] cnt;
  event_t ev;
  logic fin;
  logic upd;
  logic inf;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] elapsed_r;
  logic [TIME_W-1:0] drem;
  logic [PROG_W-1:0] dlo;
  logic [TIME_W-1:0] drem_next;
  logic [TIME_W:0] dtrial;
  logic [COMP_W-1:0] mag [NLANES];
  logic neg [NLANES];
  logic [COMP_W-1:0] lrem [NLANES];
  logic [PROG_W-1:0] llo [NLANES];
  logic [COMP_W-1:0] lrem_next [NLANES];
  logic [COMP_W:0] ltrial [NLANES];
  logic [COMP_W-1:0] res [NLANES];
  logic signed [COMP_W:0] diff [NLANES];

  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign elapsed = now_ms - start_time;

  always_comb begin
    dtrial = {drem, dlo[PROG_W-1]};
    if (dtrial >= {1'b0, run_len}) begin
      drem_next = TIME_W'(dtrial - {1'b0, run_len});
    end else begin
      drem_next = dtrial[TIME_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < NLANES; k++) begin
      ltrial[k] = {lrem[k], llo[k][PROG_W-1]};
      if (ltrial[k] >= {1'b0, PMAX}) begin
        lrem_next[k] = COMP_W'(ltrial[k] - {1'b0, PMAX});
      end else begin
        lrem_next[k] = ltrial[k][COMP_W-1:0];
      end
      diff[k] = $signed({to_rect[COMP_W*k+COMP_W-1], to_rect[COMP_W*k +: COMP_W]})
              - $signed({from_rect[COMP_W*k+COMP_W-1], from_rect[COMP_W*k +: COMP_W]});
      if (neg[k]) begin
        res[k] = from_rect[COMP_W*k +: COMP_W] - llo[k];
      end else begin
        res[k] = from_rect[COMP_W*k +: COMP_W] + llo[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_IDLE;
      start_time <= '0;
      delay_len <= '0;
      run_len <= RESET_DURATION;
      from_rect <= '0;
      to_rect <= '0;
      cnt <= '0;
      ev <= EV_NONE;
      fin <= 1'b0;
      upd <= 1'b0;
      inf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELAY: delay_len <= cfg_data[TIME_W-1:0];
          REG_DURATION: run_len <= cfg_data[TIME_W-1:0];
          REG_FROM: from_rect <= cfg_data;
          REG_TO: to_rect <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ev <= EV_NONE;
            fin <= 1'b0;
            upd <= 1'b0;
            inf <= 1'b0;
            state <= ST_OUT;
            case (action)
              ACT_TICK: begin
                if (phase == PH_DELAY) begin
                  if (elapsed >= delay_len) begin
                    start_time <= now_ms;
                    phase <= PH_RUN;
                    ev <= EV_STARTED;
                  end
                end else if (phase == PH_RUN) begin
                  if (run_len == DURATION_INFINITE) begin
                    inf <= 1'b1;
                    upd <= 1'b1;
                    state <= ST_MUL1;
                  end else if (elapsed >= run_len) begin
                    ev <= EV_STOPPED;
                    fin <= 1'b1;
                    phase <= PH_IDLE;
                    start_time <= '0;
                  end else begin
                    upd <= 1'b1;
                    state <= ST_MUL1;
                  end
                end
              end
              ACT_SCHEDULE: begin
                if (phase == PH_DELAY || phase == PH_RUN) begin
                  ev <= EV_STOPPED;
                  fin <= (phase == PH_DELAY);
                end
                phase <= PH_DELAY;
                start_time <= now_ms;
              end
              ACT_UNSCHEDULE: begin
                if (phase == PH_DELAY || phase == PH_RUN) begin
                  ev <= EV_STOPPED;
                  fin <= (phase == PH_DELAY);
                  phase <= PH_IDLE;
                  start_time <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL1: begin
          cnt <= '0;
          state <= inf ? ST_MUL2 : ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          cnt <= '0;
          state <= ST_LERP;
        end
        ST_LERP: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            event_res <= upd ? EV_UPDATE : ev;
            finished <= fin;
            progress <= upd ? dlo : '0;
            rect_x <= upd ? $signed(res[0]) : '0;
            rect_y <= upd ? $signed(res[1]) : '0;
            rect_w <= upd ? $signed(res[2]) : '0;
            rect_h <= upd ? $signed(res[3]) : '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        elapsed_r <= elapsed;
      end
      ST_MUL1: begin
        if (inf) begin
          dlo <= PMAX;
        end else begin
          {drem, dlo} <= (TIME_W + PROG_W)'(elapsed_r) * (TIME_W + PROG_W)'(PMAX);
        end
        for (int k = 0; k < NLANES; k++) begin
          neg[k] <= diff[k][COMP_W];
          mag[k] <= diff[k][COMP_W] ? COMP_W'(-diff[k]) : diff[k][COMP_W-1:0];
        end
      end
      ST_DIV: begin
        drem <= drem_next;
        dlo <= {dlo[PROG_W-2:0], (dtrial >= {1'b0, run_len})};
      end
      ST_MUL2: begin
        for (int k = 0; k < NLANES; k++) begin
          {lrem[k], llo[k]} <= (COMP_W + PROG_W)'(mag[k]) * (COMP_W + PROG_W)'(dlo);
        end
      end
      ST_LERP: begin
        for (int k = 0; k < NLANES; k++) begin
          lrem[k] <= lrem_next[k];
          llo[k] <= {llo[k][PROG_W-2:0], (ltrial[k] >= {1'b0, PMAX})};
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_fin_only_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> event_res == EV_STOPPED)
    else $error("finished set on a result that is not a stop");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_UPDATE |-> progress == '0 && rect_x == '0 &&
      rect_y == '0 && rect_w == '0 && rect_h == '0)
    else $error("payload not cleared on a result without update");

  a_prog_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_UPDATE |-> progress <= PMAX)
    else $error("progress above its maximum");

  a_div_to_lerp: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && cnt == LAST_STEP |=> state == ST_MUL2)
    else $error("progress division did not hand over to scaling");
`endif

endmodule

// File: tb/rect_tween_animation_timer_tb.sv
module rect_tween_animation_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtat_pkg::*;

  localparam int PROG_MAX = 65535;
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int DRAIN_CYCLES = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRESSURE_HOLD = 320;
  localparam int MAX_REPORTS = 40;

  typedef enum logic [1:0] {
    CH_IDLE,
    CH_DELAY,
    CH_RUN
  } chan_phase_t;

  typedef struct {
    event_t ev;
    logic fin;
    logic [15:0] prog;
    logic [3:0][15:0] rect;
  } tween_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_TICK;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] event_res;
  logic finished;
  logic [15:0] progress;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_DELAY;
  logic [63:0] cfg_data = '0;

  // Register copies and channel state of the predictor.
  logic [31:0] delay_reg = '0;
  logic [31:0] duration_reg = RESET_DURATION;
  logic [63:0] from_reg = '0;
  logic [63:0] to_reg = '0;
  chan_phase_t ch_phase = CH_IDLE;
  logic [31:0] ch_start = '0;
  logic [31:0] sim_ms = '0;

  tween_result_t due_events[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int error_count = 0;
  int requests_sent = 0;
  int register_writes = 0;
  int input_blocked_cycles = 0;
  int idle_run = 0;
  int ev_seen[4] = '{0, 0, 0, 0};

  rect_tween_animation_timer #(
    .PROGRESS_MAX(PROG_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_res(event_res),
    .finished(finished),
    .progress(progress),
    .rect_x(rect_x),
    .rect_y(rect_y),
    .rect_w(rect_w),
    .rect_h(rect_h),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] lerp_component(int k, logic [15:0] prog);
    logic signed [16:0] f;
    logic signed [16:0] t;
    logic signed [16:0] d;
    logic [16:0] mag;
    longint unsigned off;
    f = {from_reg[16*k+15], from_reg[16*k +: 16]};
    t = {to_reg[16*k+15], to_reg[16*k +: 16]};
    d = t - f;
    mag = (d < 0) ? 17'(-d) : 17'(d);
    off = (longint'(mag) * longint'(prog)) / longint'(PROG_MAX);
    return (d < 0) ? f[15:0] - off[15:0] : f[15:0] + off[15:0];
  endfunction

  function automatic tween_result_t step_channel(logic [1:0] act, logic [31:0] stamp);
    tween_result_t res;
    logic [31:0] elapsed;
    logic [15:0] prog;
    logic do_update;
    longint unsigned scaled;
    res.ev = EV_NONE;
    res.fin = 1'b0;
    res.prog = '0;
    res.rect = '0;
    elapsed = stamp - ch_start;
    do_update = 1'b0;
    prog = '0;
    case (act)
      ACT_TICK: begin
        if (ch_phase == CH_DELAY) begin
          if (elapsed >= delay_reg) begin
            ch_start = stamp;
            ch_phase = CH_RUN;
            res.ev = EV_STARTED;
          end
        end else if (ch_phase == CH_RUN) begin
          if (duration_reg == DURATION_INFINITE) begin
            prog = 16'(PROG_MAX);
            do_update = 1'b1;
          end else if (elapsed >= duration_reg) begin
            res.ev = EV_STOPPED;
            res.fin = 1'b1;
            ch_phase = CH_IDLE;
            ch_start = '0;
          end else begin
            scaled = (longint'(PROG_MAX) * longint'(elapsed)) / longint'(duration_reg);
            prog = scaled[15:0];
            do_update = 1'b1;
          end
        end
      end
      ACT_SCHEDULE: begin
        if (ch_phase != CH_IDLE) begin
          res.ev = EV_STOPPED;
          res.fin = (ch_phase == CH_DELAY);
        end
        ch_phase = CH_DELAY;
        ch_start = stamp;
      end
      ACT_UNSCHEDULE: begin
        if (ch_phase != CH_IDLE) begin
          res.ev = EV_STOPPED;
          res.fin = (ch_phase == CH_DELAY);
          ch_phase = CH_IDLE;
          ch_start = '0;
        end
      end
      default: ;
    endcase
    if (do_update) begin
      res.ev = EV_UPDATE;
      res.prog = prog;
      for (int k = 0; k < 4; k++) res.rect[k] = lerp_component(k, prog);
    end
    return res;
  endfunction

  task automatic send_request(logic [1:0] act, logic [31:0] stamp);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    now_ms <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_events.push_back(step_channel(act, stamp));
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(logic [31:0] dly, logic [31:0] dur,
                                   logic [63:0] from_r, logic [63:0] to_r);
    logic [63:0] values[4];
    values[REG_DELAY] = {32'd0, dly};
    values[REG_DURATION] = {32'd0, dur};
    values[REG_FROM] = from_r;
    values[REG_TO] = to_r;
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= values[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (2'(i))
        REG_DELAY: delay_reg = values[i][31:0];
        REG_DURATION: duration_reg = values[i][31:0];
        REG_FROM: from_reg = values[i];
        REG_TO: to_reg = values[i];
        default: ;
      endcase
      register_writes++;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_rect();
    logic [63:0] r;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0: r[16*k +: 16] = 16'h8000;
        1: r[16*k +: 16] = 16'h7FFF;
        2: r[16*k +: 16] = 16'h0000;
        default: r[16*k +: 16] = 16'($urandom);
      endcase
    end
    return r;
  endfunction

  // Mostly well-formed animations: schedule, ticks that walk through the delay
  // and the running phase, with restarts, cancels and some noise mixed in.
  task automatic choose_request(output logic [1:0] act, output logic [31:0] stamp);
    int r;
    longint unsigned stride_cap;
    r = $urandom_range(0, 99);
    stride_cap = (longint'(delay_reg) + longint'(duration_reg)) >> 3;
    if (stride_cap > 64'h7FFF_FFFF) stride_cap = 64'h7FFF_FFFF;
    stamp = sim_ms + $urandom_range(0, 32'(stride_cap) * 2 + 1);
    if (r < 3) begin
      act = 2'($urandom_range(0, 3));
      stamp = $urandom;
    end else if (r < 9) begin
      act = 2'($urandom_range(0, 3));
    end else if (ch_phase == CH_IDLE) begin
      act = (r < 20) ? ACT_TICK : ACT_SCHEDULE;
    end else if (r < 13) begin
      act = ACT_SCHEDULE;
    end else if (r < 16) begin
      act = ACT_UNSCHEDULE;
    end else begin
      act = ACT_TICK;
      if (r < 30)
        stamp = ch_start + ((ch_phase == CH_DELAY) ? delay_reg : duration_reg)
                - 32'($urandom_range(0, 1));
    end
    sim_ms = stamp;
  endtask

  task automatic play_random(int count);
    int sent;
    logic [31:0] dly;
    logic [31:0] dur;
    logic [1:0] act;
    logic [31:0] stamp;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0: dly = '0;
        1: dly = '1;
        2: dly = $urandom;
        default: dly = $urandom_range(0, 200);
      endcase
      case ($urandom_range(0, 11))
        0: dur = '0;
        1: dur = 32'd1;
        2: dur = DURATION_INFINITE;
        3: dur = 32'hFFFF_FFFE;
        4: dur = $urandom;
        default: dur = $urandom_range(1, 2000);
      endcase
      program_registers(dly, dur, pick_rect(), pick_rect());
      sim_ms = $urandom;
      repeat ($urandom_range(20, 60)) begin
        choose_request(act, stamp);
        send_request(act, stamp);
        if (act != ACT_RESERVED) sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct = 0;
    program_registers(32'd100, 32'd1000,
                      {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000},
                      {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF});
    send_request(ACT_TICK, 32'd0);
    send_request(ACT_UNSCHEDULE, 32'd5);
    send_request(ACT_RESERVED, 32'hFFFF_FFFF);
    send_request(ACT_SCHEDULE, 32'hFFFF_FFF0);
    send_request(ACT_TICK, 32'h0000_0022);
    send_request(ACT_TICK, 32'h0000_0054);
    send_request(ACT_TICK, 32'h0000_0054);
    send_request(ACT_TICK, 32'h0000_0054 + 32'd500);
    send_request(ACT_RESERVED, 32'h0000_0054 + 32'd600);
    send_request(ACT_TICK, 32'h0000_0054 + 32'd1000);
    send_request(ACT_SCHEDULE, 32'd1000);
    send_request(ACT_SCHEDULE, 32'd1010);
    send_request(ACT_TICK, 32'd1110);
    send_request(ACT_SCHEDULE, 32'd1200);
    send_request(ACT_TICK, 32'd1300);
    send_request(ACT_UNSCHEDULE, 32'd1400);
    send_request(ACT_SCHEDULE, 32'd1500);
    send_request(ACT_UNSCHEDULE, 32'd1501);
    program_registers(32'd0, 32'd0, '0, '1);
    send_request(ACT_SCHEDULE, 32'd0);
    send_request(ACT_TICK, 32'd0);
    send_request(ACT_TICK, 32'd0);
    program_registers(32'hFFFF_FFFF, DURATION_INFINITE,
                      {4{16'h8000}}, {4{16'h7FFF}});
    send_request(ACT_SCHEDULE, 32'd7);
    send_request(ACT_TICK, 32'd5);
    send_request(ACT_TICK, 32'd6);
    send_request(ACT_TICK, 32'h8000_0000);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    play_random(420);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 63;
    stall_pct = 0;
    play_random(420);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 63;
    play_random(420);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 22;
    stall_pct = 22;
    play_random(420);
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the result register and the working registers fill and input stalls.
  task automatic test_backpressure_hold();
    logic [1:0] act;
    logic [31:0] stamp;
    send_idle_pct = 0;
    stall_pct = 0;
    program_registers(32'd0, 32'd5000, pick_rect(), pick_rect());
    sim_ms = $urandom;
    @(posedge clk);
    hold_request = PRESSURE_HOLD;
    send_request(ACT_SCHEDULE, sim_ms);
    repeat (60) begin
      choose_request(act, stamp);
      send_request(act, stamp);
    end
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    tween_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual event %0d",
                   $time, event_res);
      end else begin
        want = due_events.pop_front();
        ev_seen[event_res]++;
        check_field("event_res", 16'(want.ev), 16'(event_res));
        check_field("finished", 16'(want.fin), 16'(finished));
        check_field("progress", want.prog, progress);
        check_field("rect_x", want.rect[0], rect_x);
        check_field("rect_y", want.rect[1], rect_y);
        check_field("rect_w", want.rect[2], rect_w);
        check_field("rect_h", want.rect[3], rect_h);
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && !in_ready) input_blocked_cycles++;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_run = 0;
    else
      idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_run, due_events.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure_hold();
    wait_drained();
    if (due_events.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d expected results never arrived", $time, due_events.size());
    end
    $display("Sent %0d requests and %0d register writes under four idle mixes and one hold.",
             requests_sent, register_writes);
    $display("Results: %0d none, %0d started, %0d updates, %0d stopped; input blocked %0d cycles.",
             ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3], input_blocked_cycles);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/rtat_pkg.sv
rtl/rect_tween_animation_timer.sv
tb/rect_tween_animation_timer_tb.sv
